// File: src/scct_pkg.sv
// Shared types and constants for the smartcard character transceiver.
// No dependencies; compile first.
package scct_pkg;

    // Character format
    localparam int DATA_BITS_N = 8;
    localparam int BYTE_W      = 8;
    localparam int BC_W        = 4;

    // Bit-count marks within one character frame
    localparam logic [BC_W-1:0] BC_TX_PAR  = BC_W'(DATA_BITS_N + 1);
    localparam logic [BC_W-1:0] BC_TX_ACK  = BC_W'(DATA_BITS_N + 4);
    localparam logic [BC_W-1:0] BC_RX_PAR  = BC_W'(DATA_BITS_N);
    localparam logic [BC_W-1:0] BC_RX_DONE = BC_W'(DATA_BITS_N + 3);
    localparam logic [BC_W-1:0] BC_FIRST   = BC_W'(1);

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_SEND = 2'd1,
        OP_ARM  = 2'd2,
        OP_EDGE = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_TX_START  = 4'd1,
        PH_TX_DATA   = 4'd2,
        PH_TX_PARITY = 4'd3,
        PH_TX_STOP   = 4'd4,
        PH_TX_ERR    = 4'd5,
        PH_TX_FINAL  = 4'd6,
        PH_RX_WAIT   = 4'd7,
        PH_RX_DATA   = 4'd8,
        PH_RX_PARITY = 4'd9,
        PH_RX_STOP   = 4'd10,
        PH_RX_ERR    = 4'd11
    } t_phase;

    typedef struct packed {
        t_op               opcode;
        logic [BYTE_W-1:0] tx_byte;
        logic              line_level;
    } t_item;

    typedef struct packed {
        logic              line_drive;
        logic              tx_done;
        logic              rx_valid;
        logic [BYTE_W-1:0] rx_byte;
        logic              error_event;
        logic              busy_res;
    } t_result;

endpackage

// File: src/scct_cmd_if.sv
// Command channel: valid/ready handshake carrying one event word.
// No dependencies.
interface scct_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] tx_byte;
    logic       line_level;

    modport source (output valid, output opcode, output tx_byte, output line_level,
                    input ready);
    modport sink   (input valid, input opcode, input tx_byte, input line_level,
                    output ready);
endinterface

// File: src/scct_res_if.sv
// Result channel: valid/ready handshake carrying one result word.
// No dependencies.
interface scct_res_if;
    logic       valid;
    logic       ready;
    logic       line_drive;
    logic       tx_done;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       error_event;
    logic       busy_res;

    modport source (output valid, output line_drive, output tx_done, output rx_valid,
                    output rx_byte, output error_event, output busy_res,
                    input ready);
    modport sink   (input valid, input line_drive, input tx_done, input rx_valid,
                    input rx_byte, input error_event, input busy_res,
                    output ready);
endinterface

// File: src/scct_in_stage.sv
// Input register for command words.
// Depends on scct_pkg and scct_cmd_if.
module scct_in_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    scct_cmd_if.sink         i_cmd,
    input  logic             i_can_load,   // result register free this cycle
    output logic             o_step,       // held word is processed this cycle
    output scct_pkg::t_item  o_item
);
    import scct_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_step      = r_valid && i_can_load;
    assign i_cmd.ready = !r_valid || o_step;
    assign o_item      = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_item.opcode     <= t_op'(i_cmd.opcode);
            r_item.tx_byte    <= i_cmd.tx_byte;
            r_item.line_level <= i_cmd.line_level;
        end
    end
endmodule

// File: src/scct_core.sv
// Character state machine and shift datapath; one event per step.
// Depends on scct_pkg.
module scct_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  scct_pkg::t_item    i_item,
    output scct_pkg::t_result  o_result
);
    import scct_pkg::*;

    t_phase                 r_phase, n_phase;
    logic [BC_W-1:0]        r_bc, n_bc;
    logic [DATA_BITS_N-1:0] r_shift, n_shift;
    logic [BYTE_W-1:0]      r_held, n_held;
    logic                   r_par, n_par;
    logic                   r_spar, n_spar;
    logic                   r_drive, n_drive;

    t_phase          ph_cur;
    logic [BC_W-1:0] bc_inc;
    logic            lvl;
    logic            do_send, do_arm, do_edge, is_tick;
    logic            par_ok;

    // Out-of-range codes behave as idle
    assign ph_cur  = (r_phase > PH_RX_ERR) ? PH_IDLE : r_phase;
    assign bc_inc  = r_bc + BC_FIRST;
    assign lvl     = i_item.line_level;
    assign do_send = (i_item.opcode == OP_SEND) && (ph_cur == PH_IDLE);
    assign do_arm  = (i_item.opcode == OP_ARM)  && (ph_cur == PH_IDLE);
    assign do_edge = (i_item.opcode == OP_EDGE) && (ph_cur == PH_RX_WAIT) && !lvl;
    assign is_tick = (i_item.opcode == OP_TICK);
    assign par_ok  = (r_spar == r_par);

    // Next phase
    always_comb begin
        n_phase = ph_cur;
        if (do_send) begin
            n_phase = PH_TX_DATA;
        end else if (do_arm) begin
            n_phase = PH_RX_WAIT;
        end else if (do_edge) begin
            n_phase = PH_RX_DATA;
        end else if (is_tick) begin
            unique case (ph_cur)
                PH_TX_START:  n_phase = PH_TX_DATA;
                PH_TX_DATA:   n_phase = (bc_inc == BC_TX_PAR) ? PH_TX_PARITY : PH_TX_DATA;
                PH_TX_PARITY: n_phase = PH_TX_STOP;
                PH_TX_STOP: begin
                    if (bc_inc == BC_TX_ACK) begin
                        n_phase = lvl ? PH_TX_FINAL : PH_TX_ERR;
                    end
                end
                PH_TX_ERR:    n_phase = PH_TX_START;
                PH_TX_FINAL:  n_phase = PH_IDLE;
                PH_RX_DATA:   n_phase = (bc_inc == BC_RX_PAR) ? PH_RX_PARITY : PH_RX_DATA;
                PH_RX_PARITY: n_phase = PH_RX_STOP;
                PH_RX_STOP: begin
                    if (!par_ok) begin
                        n_phase = PH_RX_ERR;
                    end else if (bc_inc == BC_RX_DONE) begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_RX_ERR:    n_phase = PH_RX_WAIT;
                default:      n_phase = ph_cur;
            endcase
        end
    end

    // Datapath and result word
    always_comb begin
        n_bc     = r_bc;
        n_shift  = r_shift;
        n_held   = r_held;
        n_par    = r_par;
        n_spar   = r_spar;
        n_drive  = r_drive;
        o_result = '0;
        if (do_send) begin
            n_held  = i_item.tx_byte;
            n_drive = 1'b0;
            n_shift = i_item.tx_byte[DATA_BITS_N-1:0];
            n_par   = 1'b0;
            n_bc    = BC_FIRST;
        end else if (do_arm || do_edge) begin
            n_bc    = '0;
            n_shift = '0;
            n_par   = 1'b0;
        end else if (is_tick) begin
            unique case (ph_cur)
                PH_TX_START: begin
                    n_drive = 1'b0;
                    n_shift = r_held[DATA_BITS_N-1:0];
                    n_par   = 1'b0;
                    n_bc    = BC_FIRST;
                end
                PH_TX_DATA: begin
                    n_drive = r_shift[0];
                    n_par   = r_par ^ r_shift[0];
                    n_shift = r_shift >> 1;
                    n_bc    = bc_inc;
                end
                PH_TX_PARITY: begin
                    n_drive = r_par;
                    n_bc    = bc_inc;
                end
                PH_TX_STOP: begin
                    n_drive = 1'b1;
                    n_bc    = bc_inc;
                    // card NAK: line held low at the acknowledge sample
                    o_result.error_event = (bc_inc == BC_TX_ACK) && !lvl;
                end
                PH_TX_ERR: begin
                    n_drive = 1'b1;
                    n_bc    = '0;
                    n_par   = 1'b0;
                end
                PH_TX_FINAL: begin
                    n_drive          = 1'b1;
                    o_result.tx_done = 1'b1;
                end
                PH_RX_DATA: begin
                    n_par = r_par ^ lvl;
                    for (int i = 0; i < DATA_BITS_N; i++) begin
                        n_shift[i] = r_shift[i] | (lvl && (r_bc == BC_W'(i)));
                    end
                    n_bc = bc_inc;
                end
                PH_RX_PARITY: begin
                    n_spar = lvl;
                    n_bc   = bc_inc;
                end
                PH_RX_STOP: begin
                    if (par_ok) begin
                        n_bc = bc_inc;
                        if (bc_inc == BC_RX_DONE) begin
                            o_result.rx_valid = 1'b1;
                            o_result.rx_byte  = BYTE_W'(r_shift);
                        end
                    end else begin
                        n_drive              = 1'b0;
                        o_result.error_event = 1'b1;
                    end
                end
                PH_RX_ERR: begin
                    n_drive = 1'b1;
                    n_bc    = '0;
                    n_par   = 1'b0;
                    n_shift = '0;
                end
                default: ;
            endcase
        end
        o_result.line_drive = n_drive;
        o_result.busy_res   = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_bc    <= '0;
            r_shift <= '0;
            r_held  <= '0;
            r_par   <= 1'b0;
            r_spar  <= 1'b0;
            r_drive <= 1'b1;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_bc    <= n_bc;
            r_shift <= n_shift;
            r_held  <= n_held;
            r_par   <= n_par;
            r_spar  <= n_spar;
            r_drive <= n_drive;
        end
    end
endmodule

// File: src/scct_out_stage.sv
// Result register driving the result channel.
// Depends on scct_pkg and scct_res_if.
module scct_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  scct_pkg::t_result  i_result,
    output logic               o_can_load,
    scct_res_if.source         o_res
);
    import scct_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_can_load = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.line_drive  = r_result.line_drive;
    assign o_res.tx_done     = r_result.tx_done;
    assign o_res.rx_valid    = r_result.rx_valid;
    assign o_res.rx_byte     = r_result.rx_byte;
    assign o_res.error_event = r_result.error_event;
    assign o_res.busy_res    = r_result.busy_res;
endmodule

// File: src/smartcard_char_transceiver_unit.sv
// Smartcard character transceiver, top level: ISO 7816 T=0 style character layer
// for a half-duplex IO line. Each command word is one event: an ETU tick with the
// sampled line level, send byte, arm receive, or start edge seen. Every accepted
// word yields exactly one result word carrying the line drive level (0 pulls low,
// 1 releases), tx_done, rx_valid with rx_byte, error_event and busy_res. Transmit
// sends start, 8 data bits LSB first, even parity, then samples the card's
// acknowledge at the twelfth ETU and resends after a NAK. Receive checks parity
// and signals a NAK by pulling the line low for one ETU. Send and arm commands
// while busy, and start edges while not armed, are ignored. Throughput is one word
// per clock while results are taken; a result passes through the input register,
// the state update and the result register. While a finished result waits to be
// taken, the command side takes one more word into the input register and then
// holds ready low until the result drains.
// Depends on scct_pkg, scct_cmd_if, scct_res_if, scct_in_stage, scct_core,
// scct_out_stage.
module smartcard_char_transceiver_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    scct_cmd_if.sink    i_cmd,
    scct_res_if.source  o_res
);
    import scct_pkg::*;

    logic    step;       // held command word goes through the core
    logic    can_load;   // result register empty or being drained
    t_item   item;
    t_result result;

    // Input register; advances only when the result register can take the result
    scct_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (i_cmd),
        .i_can_load (can_load),
        .o_step     (step),
        .o_item     (item)
    );

    // Character state and datapath, updated once per processed word
    scct_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (item),
        .o_result (result)
    );

    // Result register on the output channel
    scct_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (step),
        .i_result   (result),
        .o_can_load (can_load),
        .o_res      (o_res)
    );

    // A word never reports transmit and receive completion together
    a_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !(o_res.tx_done && o_res.rx_valid))
        else $error("tx_done and rx_valid in one result word");

    // Completion of a received byte always returns the block to idle
    a_rx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.rx_valid) |-> !o_res.busy_res)
        else $error("rx_valid while still busy");

    // Transmit acknowledge and error never coincide
    a_done_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !(o_res.tx_done && o_res.error_event))
        else $error("tx_done together with error_event");

    // No result word appears without a command processed the cycle before
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_res.valid)) |-> $past(step))
        else $error("result word without a processed command");
endmodule
